// ===== src/wpe_pkg.sv =====
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types and constants of the window pooling engine.
// ----------------------------------------------------------------------------
package wpe_pkg;

  // Store geometry
  localparam int unsigned MAX_ROWS     = 32;
  localparam int unsigned MAX_COLS     = 32;
  localparam int unsigned MAX_CHANNELS = 16;

  localparam int unsigned KERNEL_LIMIT = 16;
  localparam int unsigned CFG_COUNT    = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 6;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_MAX   = 2'd1,
    REQ_AVG   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_MAP_HEIGHT   = 3'd0,
    CFG_MAP_WIDTH    = 3'd1,
    CFG_KERNEL_ROWS  = 3'd2,
    CFG_KERNEL_COLS  = 3'd3,
    CFG_STEP_ROWS    = 3'd4,
    CFG_STEP_COLS    = 3'd5,
    CFG_PAD_ABOVE    = 3'd6,
    CFG_PAD_LEFTSIDE = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_FINISH,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  // Settings held by the configuration block.
  typedef struct packed {
    logic [5:0] map_height;
    logic [5:0] map_width;
    logic [4:0] kernel_rows;
    logic [4:0] kernel_cols;
    logic [4:0] step_rows;
    logic [4:0] step_cols;
    logic [3:0] pad_above;
    logic [3:0] pad_leftside;
  } cfg_t;

  // Handshake between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/wpe_if.sv =====
// ----------------------------------------------------------------------------
// wpe_in_if / wpe_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface wpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [5:0]         row;
  logic [5:0]         col;
  logic [3:0]         chan;
  logic signed [15:0] sample;
  modport source (output valid, req_type, row, col, chan, sample, input ready);
  modport sink   (input valid, req_type, row, col, chan, sample, output ready);
endinterface

interface wpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pooled;
  logic [8:0]         used_count;
  modport source (output valid, pooled, used_count, input ready);
  modport sink   (input valid, pooled, used_count, output ready);
endinterface

// ===== src/window_pooling_engine_unit.sv =====
// ----------------------------------------------------------------------------
// window_pooling_engine_unit
// Max and average pooling over a feature map held in a local store.
// ----------------------------------------------------------------------------
// Input channel in_ch carries write beats (store one Q8.8 sample) and query
// beats (max or average over one window); out_ch returns one beat per query.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// A write is stored as its beat is accepted. From the accepting edge to the
// result beat a query runs through setup, one store read per entry of the
// clipped window (one read port, one read per cycle), a drain step that folds
// in the last read and a finish step; an average then waits on the divider,
// which retires one quotient bit per cycle. One item is in flight at a time;
// after the result beat the controller returns to idle before the next beat
// is taken. If the receiver stalls, the result is held in place and no new
// beat is accepted. Reset returns the registers to their defaults and the
// controller to idle; store contents are undefined until written.
// ----------------------------------------------------------------------------
module window_pooling_engine_unit #(
  parameter int unsigned INCLUDE_PAD  = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  wpe_in_if.sink                         in_ch,
  wpe_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wpe_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  wpe_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  wpe_seq #(
    .INCLUDE_PAD(INCLUDE_PAD)
  ) u_seq (
    .clk, .rst, .cfg, .in_ch, .out_ch, .div_req, .div_rsp
  );

  wpe_div u_div (
    .clk, .rst, .req(div_req), .rsp(div_rsp)
  );

endmodule

// ===== src/wpe_cfg.sv =====
// ----------------------------------------------------------------------------
// wpe_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module wpe_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpe_pkg::CFG_DATA_W-1:0]     cfg_data,
  output wpe_pkg::cfg_t                      cfg
);
  import wpe_pkg::*;

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_height   <= 6'd32;
      cfg.map_width    <= 6'd32;
      cfg.kernel_rows  <= 5'd2;
      cfg.kernel_cols  <= 5'd2;
      cfg.step_rows    <= 5'd2;
      cfg.step_cols    <= 5'd2;
      cfg.pad_above    <= 4'd0;
      cfg.pad_leftside <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAP_HEIGHT:   cfg.map_height   <= cfg_data[5:0];
        CFG_MAP_WIDTH:    cfg.map_width    <= cfg_data[5:0];
        CFG_KERNEL_ROWS:  cfg.kernel_rows  <= cfg_data[4:0];
        CFG_KERNEL_COLS:  cfg.kernel_cols  <= cfg_data[4:0];
        CFG_STEP_ROWS:    cfg.step_rows    <= cfg_data[4:0];
        CFG_STEP_COLS:    cfg.step_cols    <= cfg_data[4:0];
        CFG_PAD_ABOVE:    cfg.pad_above    <= cfg_data[3:0];
        CFG_PAD_LEFTSIDE: cfg.pad_leftside <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/wpe_div.sv =====
// ----------------------------------------------------------------------------
// wpe_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module wpe_div (
  input  logic               clk,
  input  logic               rst,
  input  wpe_pkg::div_req_t  req,
  output wpe_pkg::div_rsp_t  rsp
);
  import wpe_pkg::*;

  logic [31:0] quo;
  logic [31:0] rem;
  logic [8:0]  den;
  logic        neg;
  logic        busy;
  logic        done;
  logic [4:0]  bit_cnt;
  logic [32:0] rem_shift;
  logic [32:0] rem_trial;
  logic [31:0] mag;
  logic [31:0] quo_signed;

  assign mag       = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
  assign rem_shift = {rem, quo[31]};
  assign rem_trial = rem_shift - {24'd0, den};
  assign quo_signed = neg ? (~quo + 32'd1) : quo;

  // Shift one bit through the remainder each cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        quo     <= mag;
        rem     <= 32'd0;
        den     <= (req.divisor == 9'd0) ? 9'd1 : req.divisor;
        neg     <= req.dividend[31];
        bit_cnt <= 5'd31;
      end else if (busy) begin
        if (rem_trial[32]) begin
          rem <= rem_shift[31:0];
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= rem_trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end
        bit_cnt <= bit_cnt - 5'd1;
        if (bit_cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo_signed[15:0];

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) rsp.done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without work");

  property p_no_start_busy;
    @(posedge clk) disable iff (rst) busy |-> !req.start;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy)
    else $error("divider restarted while busy");

  property p_den_nonzero;
    @(posedge clk) disable iff (rst) busy |-> den != 9'd0;
  endproperty
  a_den_nonzero: assert property (p_den_nonzero)
    else $error("zero divisor in flight");

endmodule

// ===== src/wpe_seq.sv =====
// ----------------------------------------------------------------------------
// wpe_seq
// Owns the feature store and walks the clipped window one read per cycle.
// ----------------------------------------------------------------------------
module wpe_seq #(
  parameter int unsigned INCLUDE_PAD  = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  wpe_pkg::cfg_t     cfg,
  wpe_in_if.sink            in_ch,
  wpe_out_if.source         out_ch,
  output wpe_pkg::div_req_t div_req,
  input  wpe_pkg::div_rsp_t div_rsp
);
  import wpe_pkg::*;

  localparam int unsigned ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ADDR_W  = ROW_W + COL_W + CH_W;
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS * MAX_CHANNELS;

  logic [15:0] store [DEPTH];
  logic [15:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  state_t state, state_next;

  // Latched query
  logic        is_max;
  logic [5:0]  q_row, q_col;
  logic [3:0]  q_chan;
  // Window bounds, absolute coordinates
  logic signed [12:0] y_hi, x_lo, x_hi;
  logic signed [12:0] y_cur, x_cur;
  logic [8:0]  count;
  logic signed [31:0] acc;
  logic        rd_valid;
  logic        chan_ok;
  logic signed [15:0] pooled_r;

  // Saturated sizes and origins
  logic [5:0] h_sat, w_sat;
  logic [4:0] kr_sat, kc_sat;
  logic signed [12:0] oy, ox;
  logic signed [12:0] ylo_c, yhi_c, xlo_c, xhi_c;
  logic [12:0] ye_minus, xe_minus;
  logic last_read;
  logic [9:0] area;

  assign h_sat  = (cfg.map_height > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : cfg.map_height;
  assign w_sat  = (cfg.map_width  > 6'(MAX_COLS)) ? 6'(MAX_COLS) : cfg.map_width;
  assign kr_sat = (cfg.kernel_rows > 5'(KERNEL_LIMIT)) ? 5'(KERNEL_LIMIT) : cfg.kernel_rows;
  assign kc_sat = (cfg.kernel_cols > 5'(KERNEL_LIMIT)) ? 5'(KERNEL_LIMIT) : cfg.kernel_cols;
  assign oy = $signed({2'b0, 6'(q_row) * 11'(cfg.step_rows)}) - $signed({9'd0, cfg.pad_above});
  assign ox = $signed({2'b0, 6'(q_col) * 11'(cfg.step_cols)}) - $signed({9'd0, cfg.pad_leftside});

  // Clip each axis to [0, size)
  always_comb begin
    ylo_c = (oy < 0) ? 13'sd0 : oy;
    yhi_c = oy + $signed({8'd0, kr_sat});
    if (yhi_c > $signed({7'd0, h_sat})) yhi_c = $signed({7'd0, h_sat});
    if (yhi_c < ylo_c) yhi_c = ylo_c;
    xlo_c = (ox < 0) ? 13'sd0 : ox;
    xhi_c = ox + $signed({8'd0, kc_sat});
    if (xhi_c > $signed({7'd0, w_sat})) xhi_c = $signed({7'd0, w_sat});
    if (xhi_c < xlo_c) xhi_c = xlo_c;
  end
  assign ye_minus = 13'(yhi_c - ylo_c);
  assign xe_minus = 13'(xhi_c - xlo_c);
  assign area     = 10'(kr_sat) * 10'(kc_sat);

  assign last_read = (x_cur == x_hi - 13'sd1) && (y_cur == y_hi - 13'sd1);

  // Store address for writes and window reads
  assign wr_addr = {in_ch.row[ROW_W-1:0], in_ch.col[COL_W-1:0], in_ch.chan[CH_W-1:0]};
  assign rd_addr = {y_cur[ROW_W-1:0], x_cur[COL_W-1:0], q_chan[CH_W-1:0]};
  assign wr_en   = in_ch.valid && in_ch.ready && (req_t'(in_ch.req_type) == REQ_WRITE)
                   && (32'(in_ch.row) < MAX_ROWS) && (32'(in_ch.col) < MAX_COLS)
                   && (32'(in_ch.chan) < MAX_CHANNELS);

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= in_ch.sample;
    rd_data <= store[rd_addr];
  end

  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign chan_ok     = 32'(q_chan) < MAX_CHANNELS;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (in_ch.valid && (req_t'(in_ch.req_type) == REQ_MAX
                            || req_t'(in_ch.req_type) == REQ_AVG))
          state_next = ST_SETUP;
      ST_SETUP:
        state_next = (ye_minus == 13'd0 || xe_minus == 13'd0) ? ST_DRAIN : ST_READ;
      ST_READ:
        if (last_read) state_next = ST_DRAIN;
      // The last read is folded in here
      ST_DRAIN:
        state_next = ST_FINISH;
      ST_FINISH:
        state_next = is_max ? ST_OUTPUT : ST_DIVIDE;
      ST_DIVIDE:
        if (div_rsp.done) state_next = ST_OUTPUT;
      ST_OUTPUT:
        if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    div_req.start    = (state == ST_FINISH) && !is_max;
    div_req.dividend = acc;
    div_req.divisor  = (INCLUDE_PAD != 0) ? area[8:0] : count;
    out_ch.valid     = (state == ST_OUTPUT);
  end
  assign out_ch.pooled     = pooled_r;
  assign out_ch.used_count = count;

  // Advance through the window and fold in each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_READ);
    end
    if (in_ch.valid && in_ch.ready) begin
      is_max <= (req_t'(in_ch.req_type) == REQ_MAX);
      q_row  <= in_ch.row;
      q_col  <= in_ch.col;
      q_chan <= in_ch.chan;
    end
    if (state == ST_SETUP) begin
      y_hi  <= yhi_c;
      x_lo  <= xlo_c;  x_hi <= xhi_c;
      y_cur <= ylo_c;  x_cur <= xlo_c;
      count <= 9'(ye_minus[4:0]) * 9'(xe_minus[4:0]);
      acc   <= is_max ? -32'sd32768 : 32'sd0;
    end
    if (state == ST_READ) begin
      if (x_cur == x_hi - 13'sd1) begin
        x_cur <= x_lo;
        y_cur <= y_cur + 13'sd1;
      end else begin
        x_cur <= x_cur + 13'sd1;
      end
    end
    if (rd_valid) begin
      if (is_max) begin
        if (chan_ok && $signed(rd_data) > acc) acc <= 32'($signed(rd_data));
        else if (!chan_ok && acc < 0) acc <= 32'sd0;
      end else if (chan_ok) begin
        acc <= acc + 32'($signed(rd_data));
      end
    end
    if (state == ST_FINISH && is_max) pooled_r <= acc[15:0];
    if (state == ST_DIVIDE && div_rsp.done) pooled_r <= div_rsp.quotient;
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) (out_ch.valid && !out_ch.ready) |=> out_ch.valid;
  endproperty
  a_ready_idle: assert property (p_ready_idle)
    else $error("result dropped under stall");

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy)
    else $error("input taken while result pending");

  property p_read_window;
    @(posedge clk) disable iff (rst) (state == ST_READ) |-> (y_cur < y_hi && x_cur < x_hi);
  endproperty
  a_read_window: assert property (p_read_window)
    else $error("read outside clipped window");

endmodule

// ===== bench/window_pooling_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_pooling_engine_unit_tb
// Self-checking bench for the window pooling engine.
// ----------------------------------------------------------------------------
// Walks a short table of hand-picked beats, then runs random write and query
// traffic under a series of register settings. A random query whose window
// still holds an unwritten entry is turned into a write of that entry, so the
// store fills as the run goes. Each result is checked against a local pooling
// predictor with its own copy of the store and registers, or against the table
// for a typed beat. Both channel sides idle at random but for one busy phase.
// ----------------------------------------------------------------------------
module window_pooling_engine_unit_tb;
  import wpe_pkg::*;

  localparam int ROWS_N  = MAX_ROWS;
  localparam int COLS_N  = MAX_COLS;
  localparam int CHANS_N = MAX_CHANNELS;
  localparam int unsigned INCL_PAD = 0;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 102;

  typedef struct {
    req_t        kind;
    int          row;
    int          col;
    int          chan;
    int          sample;
    bit          typed;
    logic [15:0] pooled;
    logic [8:0]  count;
  } beat_t;

  typedef struct {
    logic [15:0] pooled;
    logic [8:0]  count;
  } pool_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wpe_in_if  in_ch();
  wpe_out_if out_ch();

  window_pooling_engine_unit #(
    .INCLUDE_PAD (INCL_PAD)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state
  logic signed [15:0] feat_mem [ROWS_N*COLS_N*CHANS_N];
  bit          written [ROWS_N*COLS_N*CHANS_N];
  int          reg_val [CFG_COUNT];
  pool_res_t   pending_pool [$];
  int          errors = 0;
  int          cycles = 0;
  bit          busy_mode = 0;
  bit          sink_busy = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int reg_mask(cfg_idx_t idx);
    case (idx)
      CFG_MAP_HEIGHT, CFG_MAP_WIDTH: reg_mask = 'h3F;
      CFG_PAD_ABOVE, CFG_PAD_LEFTSIDE: reg_mask = 'hF;
      default: reg_mask = 'h1F;
    endcase
  endfunction

  function automatic int clamp(int v, int lim);
    clamp = (v > lim) ? lim : v;
  endfunction

  // Kernel offsets [lo, hi) of one axis that fall inside the map
  function automatic void clip_span(int org, int size, int k, output int lo, output int hi);
    lo = (org < 0) ? -org : 0;
    hi = k;
    if (org + hi > size) hi = size - org;
    if (lo > k) lo = k;
    if (hi < lo) hi = lo;
  endfunction

  // Find an entry of a query window that has not been written yet
  function automatic bit find_hole(beat_t b, output int hr, output int hc);
    int h, w, kr, kc, oy, ox, yb, ye, xb, xe;
    hr = 0;
    hc = 0;
    if (b.kind != REQ_MAX && b.kind != REQ_AVG) return 0;
    h  = clamp(reg_val[CFG_MAP_HEIGHT], ROWS_N);
    w  = clamp(reg_val[CFG_MAP_WIDTH], COLS_N);
    kr = clamp(reg_val[CFG_KERNEL_ROWS], KERNEL_LIMIT);
    kc = clamp(reg_val[CFG_KERNEL_COLS], KERNEL_LIMIT);
    oy = b.row * reg_val[CFG_STEP_ROWS] - reg_val[CFG_PAD_ABOVE];
    ox = b.col * reg_val[CFG_STEP_COLS] - reg_val[CFG_PAD_LEFTSIDE];
    clip_span(oy, h, kr, yb, ye);
    clip_span(ox, w, kc, xb, xe);
    for (int y = yb; y < ye; y++)
      for (int x = xb; x < xe; x++)
        if (!written[((oy+y)*COLS_N + ox+x)*CHANS_N + b.chan]) begin
          hr = oy + y;
          hc = ox + x;
          return 1;
        end
    return 0;
  endfunction

  // Update the store or work out one pooled result; returns 1 if a beat is due
  function automatic bit pool_predict(beat_t b, output pool_res_t res);
    int h, w, kr, kc, oy, ox, yb, ye, xb, xe, acc, cnt, den, v;
    h  = clamp(reg_val[CFG_MAP_HEIGHT], ROWS_N);
    w  = clamp(reg_val[CFG_MAP_WIDTH], COLS_N);
    kr = clamp(reg_val[CFG_KERNEL_ROWS], KERNEL_LIMIT);
    kc = clamp(reg_val[CFG_KERNEL_COLS], KERNEL_LIMIT);
    res = '{16'd0, 9'd0};
    if (b.kind == REQ_WRITE) begin
      if (b.row < ROWS_N && b.col < COLS_N && b.chan < CHANS_N) begin
        feat_mem[(b.row*COLS_N + b.col)*CHANS_N + b.chan] = b.sample[15:0];
        written[(b.row*COLS_N + b.col)*CHANS_N + b.chan] = 1'b1;
      end
      return 0;
    end
    if (b.kind == REQ_NONE) return 0;
    oy = b.row * reg_val[CFG_STEP_ROWS] - reg_val[CFG_PAD_ABOVE];
    ox = b.col * reg_val[CFG_STEP_COLS] - reg_val[CFG_PAD_LEFTSIDE];
    clip_span(oy, h, kr, yb, ye);
    clip_span(ox, w, kc, xb, xe);
    cnt = (ye - yb) * (xe - xb);
    acc = (b.kind == REQ_MAX) ? -32768 : 0;
    for (int y = yb; y < ye; y++)
      for (int x = xb; x < xe; x++) begin
        v = (b.chan < CHANS_N) ? int'(feat_mem[((oy+y)*COLS_N + ox+x)*CHANS_N + b.chan]) : 0;
        if (b.kind == REQ_MAX) begin
          if (v > acc) acc = v;
        end else begin
          acc += v;
        end
      end
    if (b.kind == REQ_AVG) begin
      den = (INCL_PAD != 0) ? kr * kc : cnt;
      if (den == 0) den = 1;
      acc = acc / den;
    end
    res.pooled = acc[15:0];
    res.count  = cnt[8:0];
    return 1;
  endfunction

  // Send one beat after a gap; record the expectation on acceptance
  task automatic send_beat(beat_t b);
    int gap;
    pool_res_t res;
    bit due;
    gap = busy_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= b.kind;
    in_ch.row      <= b.row[5:0];
    in_ch.col      <= b.col[5:0];
    in_ch.chan     <= b.chan[3:0];
    in_ch.sample   <= b.sample[15:0];
    do @(posedge clk); while (!in_ch.ready);
    due = pool_predict(b, res);
    if (due) begin
      if (b.typed) begin
        res.pooled = b.pooled;
        res.count  = b.count;
      end
      pending_pool.push_back(res);
    end
  endtask

  // Hold the sender until the engine is idle
  task automatic drain_engine();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pool.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_regs(int vals[CFG_COUNT]);
    cfg_idx_t idx;
    drain_engine();
    for (int i = 0; i < CFG_COUNT; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i][5:0];
      @(posedge clk);
      reg_val[i] = vals[i] & reg_mask(idx);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int pick;
    int hr, hc;
    pick = $urandom_range(0, 99);
    b.typed  = 0;
    b.pooled = '0;
    b.count  = '0;
    b.sample = $urandom_range(0, 65535);
    b.chan   = $urandom_range(0, 15);
    if (pick < 40) begin
      b.kind = REQ_WRITE;
      b.row  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 31);
      b.col  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 31);
    end else begin
      b.kind = (pick < 45) ? REQ_NONE : (pick < 72) ? REQ_MAX : REQ_AVG;
      b.chan = $urandom_range(0, 3);
      b.row  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
      b.col  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    end
    // Fill a hole of the window first rather than read it
    if (find_hole(b, hr, hc)) begin
      b.kind = REQ_WRITE;
      b.row  = hr;
      b.col  = hc;
    end
    return b;
  endfunction

  // Result sink: random stalls, compare against the oldest expectation
  initial begin
    pool_res_t exp_res;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = sink_busy ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_pool.size() == 0) begin
        $display("%0t: unexpected result beat pooled=%0d used_count=%0d",
                 $time, out_ch.pooled, out_ch.used_count);
        errors++;
      end else begin
        exp_res = pending_pool.pop_front();
        if (out_ch.pooled !== exp_res.pooled) begin
          $display("%0t: pooled expected %0d actual %0d", $time,
                   $signed(exp_res.pooled), out_ch.pooled);
          errors++;
        end
        if (out_ch.used_count !== exp_res.count) begin
          $display("%0t: used_count expected %0d actual %0d", $time,
                   exp_res.count, out_ch.used_count);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    beat_t dir_tab [$];
    beat_t b;
    int vals [CFG_COUNT];
    int settings [$][CFG_COUNT];
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_MAP_HEIGHT;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_WRITE;
    in_ch.row      <= '0;
    in_ch.col      <= '0;
    in_ch.chan     <= '0;
    in_ch.sample   <= '0;
    reg_val = '{32, 32, 2, 2, 2, 2, 0, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked beats under the reset settings
    dir_tab = '{
      '{REQ_WRITE, 0, 0, 0, 32767, 0, '0, '0},
      '{REQ_WRITE, 0, 1, 0, -32768, 0, '0, '0},
      '{REQ_WRITE, 1, 0, 0, 32767, 0, '0, '0},
      '{REQ_WRITE, 1, 1, 0, 32767, 0, '0, '0},
      '{REQ_MAX, 0, 0, 0, 0, 1, 16'sd32767, 9'd4},
      '{REQ_AVG, 0, 0, 0, 0, 1, 16'sd16383, 9'd4},
      '{REQ_WRITE, 30, 30, 15, -32768, 0, '0, '0},
      '{REQ_WRITE, 30, 31, 15, -32768, 0, '0, '0},
      '{REQ_WRITE, 31, 30, 15, -32768, 0, '0, '0},
      '{REQ_WRITE, 31, 31, 15, -32768, 0, '0, '0},
      '{REQ_MAX, 15, 15, 15, 0, 1, -16'sd32768, 9'd4},
      '{REQ_AVG, 15, 15, 15, 0, 1, -16'sd32768, 9'd4},
      '{REQ_NONE, 63, 63, 15, -1, 0, '0, '0},
      '{REQ_WRITE, 40, 5, 3, 1234, 0, '0, '0},
      '{REQ_WRITE, 63, 63, 15, -1, 0, '0, '0},
      '{REQ_MAX, 63, 0, 2, 0, 1, -16'sd32768, 9'd0},
      '{REQ_AVG, 0, 63, 2, 0, 1, 16'sd0, 9'd0},
      '{REQ_WRITE, 2, 2, 3, 100, 0, '0, '0},
      '{REQ_WRITE, 2, 3, 3, -200, 0, '0, '0},
      '{REQ_WRITE, 3, 2, 3, 5, 0, '0, '0},
      '{REQ_WRITE, 3, 3, 3, -7, 0, '0, '0},
      '{REQ_MAX, 1, 1, 3, 0, 0, '0, '0},
      '{REQ_WRITE, 4, 6, 7, -5, 0, '0, '0},
      '{REQ_WRITE, 4, 7, 7, -6, 0, '0, '0},
      '{REQ_WRITE, 5, 6, 7, -7, 0, '0, '0},
      '{REQ_WRITE, 5, 7, 7, 8, 0, '0, '0},
      '{REQ_AVG, 2, 3, 7, 0, 0, '0, '0},
      '{REQ_WRITE, 30, 28, 9, 300, 0, '0, '0},
      '{REQ_WRITE, 30, 29, 9, -1, 0, '0, '0},
      '{REQ_WRITE, 31, 28, 9, 7, 0, '0, '0},
      '{REQ_WRITE, 31, 29, 9, 2, 0, '0, '0},
      '{REQ_AVG, 15, 14, 9, 0, 0, '0, '0}
    };
    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    // Settings sweep: extremes and fixed mixes first, then random ones, then the reset settings
    settings.push_back('{63, 63, 63, 63, 63, 63, 63, 63});
    settings.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
    settings.push_back('{1, 1, 1, 1, 1, 1, 0, 0});
    settings.push_back('{32, 32, 16, 16, 16, 16, 15, 15});
    settings.push_back('{5, 7, 3, 3, 1, 2, 1, 2});
    for (int p = 0; p < 4; p++) begin
      vals = '{$urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 5),
               $urandom_range(1, 5), $urandom_range(0, 4), $urandom_range(0, 4),
               $urandom_range(0, 3), $urandom_range(0, 3)};
      settings.push_back(vals);
    end
    settings.push_back('{32, 32, 2, 2, 2, 2, 0, 0});

    foreach (settings[p]) begin
      vals = settings[p];
      load_regs(vals);
      busy_mode = (p == 4);
      sink_busy = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        b = random_beat();
        send_beat(b);
      end
      busy_mode = 0;
      sink_busy = 0;
    end

    // Wind down
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pool.size() != 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
